@@ sv/utf8d_pkg.sv @@
// utf8d_pkg: types and constants shared by the UTF-8 stream decoder modules
// used by utf8d_core and utf8_stream_decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    // field widths
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 26;
    localparam int unsigned CountW = 3;

    // tdata width of the result channel, rounded up to whole bytes
    localparam int unsigned OutDataW = ((CpW + CountW + 7) / 8) * 8;

    // lead byte classes
    localparam logic [ByteW-1:0] LeadMask1 = 8'h80;
    localparam logic [ByteW-1:0] LeadMask2 = 8'hE0;
    localparam logic [ByteW-1:0] LeadCode2 = 8'hC0;
    localparam logic [ByteW-1:0] LeadMask3 = 8'hF0;
    localparam logic [ByteW-1:0] LeadCode3 = 8'hE0;
    localparam logic [ByteW-1:0] LeadMask4 = 8'hF8;
    localparam logic [ByteW-1:0] LeadCode4 = 8'hF0;

    // payload masks
    localparam logic [ByteW-1:0] Pay1Mask = 8'h7F;
    localparam logic [ByteW-1:0] Pay2Mask = 8'h1F;
    localparam logic [ByteW-1:0] Pay3Mask = 8'h0F;
    localparam logic [ByteW-1:0] Pay4Mask = 8'h07;
    localparam logic [ByteW-1:0] Pay5Mask = 8'h03;
    localparam logic [ByteW-1:0] ContMask = 8'h3F;

    // sequence lengths
    localparam logic [CountW-1:0] Len1 = 3'd1;
    localparam logic [CountW-1:0] Len2 = 3'd2;
    localparam logic [CountW-1:0] Len3 = 3'd3;
    localparam logic [CountW-1:0] Len4 = 3'd4;
    localparam logic [CountW-1:0] Len5 = 3'd5;

    // one decoded result leaving the core
    typedef struct packed {
        logic              valid;
        logic [CpW-1:0]    code_point;
        logic [CountW-1:0] byte_count;
        logic              truncated;
        logic              text_done;
    } utf8d_result_t;

endpackage : utf8d_pkg

`default_nettype wire

@@ sv/utf8d_core.sv @@
// utf8d_core: per-byte decode step and sequence state of the UTF-8 decoder
// depends on utf8d_pkg
`timescale 1ns / 1ps
`default_nettype none

module utf8d_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [utf8d_pkg::ByteW-1:0]   text_byte,
    input  wire logic                          end_of_text,
    output utf8d_pkg::utf8d_result_t           result
);

    logic [utf8d_pkg::CountW-1:0] remain_reg, remain_next;
    logic [utf8d_pkg::CpW-1:0]    acc_reg, acc_next;
    logic [utf8d_pkg::CountW-1:0] len_reg, len_next;

    logic [utf8d_pkg::CountW-1:0] rem_step;
    logic [utf8d_pkg::CpW-1:0]    acc_step;
    logic [utf8d_pkg::CountW-1:0] len_step;
    logic [utf8d_pkg::ByteW-1:0]  lead_bits;
    logic [utf8d_pkg::CpW-1:0]    acc_padded;

    // lead byte classification or continuation append
    always_comb
    begin
        lead_bits = '0;
        len_step  = len_reg;
        if (remain_reg == '0)
        begin
            if ((text_byte & utf8d_pkg::LeadMask1) == '0)
            begin
                len_step  = utf8d_pkg::Len1;
                lead_bits = text_byte & utf8d_pkg::Pay1Mask;
            end
            else if ((text_byte & utf8d_pkg::LeadMask2) == utf8d_pkg::LeadCode2)
            begin
                len_step  = utf8d_pkg::Len2;
                lead_bits = text_byte & utf8d_pkg::Pay2Mask;
            end
            else if ((text_byte & utf8d_pkg::LeadMask3) == utf8d_pkg::LeadCode3)
            begin
                len_step  = utf8d_pkg::Len3;
                lead_bits = text_byte & utf8d_pkg::Pay3Mask;
            end
            else if ((text_byte & utf8d_pkg::LeadMask4) == utf8d_pkg::LeadCode4)
            begin
                len_step  = utf8d_pkg::Len4;
                lead_bits = text_byte & utf8d_pkg::Pay4Mask;
            end
            else
            begin
                len_step  = utf8d_pkg::Len5;
                lead_bits = text_byte & utf8d_pkg::Pay5Mask;
            end
            acc_step = {{(utf8d_pkg::CpW - utf8d_pkg::ByteW){1'b0}}, lead_bits};
            rem_step = len_step - 3'd1;
        end
        else
        begin
            acc_step = {acc_reg[utf8d_pkg::CpW-7:0],
                        text_byte[5:0] & utf8d_pkg::ContMask[5:0]};
            rem_step = remain_reg - 3'd1;
        end
    end

    // zero payload for the bytes missing at end of text
    always_comb
    begin
        case (rem_step)
            3'd1:    acc_padded = {acc_step[utf8d_pkg::CpW-7:0],  6'd0};
            3'd2:    acc_padded = {acc_step[utf8d_pkg::CpW-13:0], 12'd0};
            3'd3:    acc_padded = {acc_step[utf8d_pkg::CpW-19:0], 18'd0};
            3'd4:    acc_padded = {acc_step[utf8d_pkg::CpW-25:0], 24'd0};
            default: acc_padded = acc_step;
        endcase
    end

    // result and next state
    always_comb
    begin
        result.valid      = 1'b0;
        result.code_point = acc_step;
        result.byte_count = len_step;
        result.truncated  = 1'b0;
        result.text_done  = end_of_text;
        remain_next       = remain_reg;
        acc_next          = acc_reg;
        len_next          = len_reg;
        if (step)
        begin
            remain_next = rem_step;
            acc_next    = acc_step;
            len_next    = len_step;
            if (rem_step == '0)
            begin
                result.valid = 1'b1;
                remain_next  = '0;
                acc_next     = '0;
                len_next     = '0;
            end
            else if (end_of_text)
            begin
                result.valid      = 1'b1;
                result.code_point = acc_padded;
                result.byte_count = len_step - rem_step;
                result.truncated  = 1'b1;
                remain_next       = '0;
                acc_next          = '0;
                len_next          = '0;
            end
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            acc_reg    <= '0;
            len_reg    <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
            len_reg    <= len_next;
        end
    end

endmodule : utf8d_core

`default_nettype wire

@@ sv/utf8_stream_decoder.sv @@
// utf8_stream_decoder: top level, input register, decode core and result register
// depends on utf8d_pkg and utf8d_core
`timescale 1ns / 1ps
`default_nettype none

// Decodes a UTF-8 byte stream into code points, one byte per clock cycle
// while no result is held back by m_tready. Each request byte is held in
// an input register, passes the decode step in utf8d_core, and a finished
// code point lands in the result register. Bytes that only
// extend a sequence produce no result. Leads of 1 to 4 bytes follow the
// usual prefixes; any other lead byte, a stray continuation byte included,
// opens a 5-byte sequence. Following bytes are taken without prefix
// checks. When s_tlast marks the end of text mid-sequence, a result with
// the truncated flag is sent, the missing bytes counted as zero payload.
// The input side keeps accepting while a result waits on m_tready, up to
// one byte in the input register.
module utf8_stream_decoder
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [utf8d_pkg::ByteW-1:0]      s_tdata,   // [7:0] text_byte
    input  wire logic                             s_tlast,   // end_of_text
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [utf8d_pkg::OutDataW-1:0]   m_tdata,   // [25:0] code_point,
                                                             // [28:26] byte_count
    output      logic                             m_tuser,   // truncated
    output      logic                             m_tlast    // text_done
);

    logic                         in_valid_reg, in_valid_next;
    logic [utf8d_pkg::ByteW-1:0]  in_byte_reg;
    logic                         in_eot_reg;
    logic                         out_valid_reg, out_valid_next;
    utf8d_pkg::utf8d_result_t     out_reg;
    utf8d_pkg::utf8d_result_t     result;
    logic                         advance;
    logic                         in_take;

    // handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // decode step
    utf8d_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .result      (result)
    );

    // next valid flags
    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && result.valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
        if (advance && result.valid)
            out_reg <= result;
    end

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(utf8d_pkg::OutDataW - utf8d_pkg::CpW - utf8d_pkg::CountW){1'b0}},
                       out_reg.byte_count, out_reg.code_point};
    assign m_tuser  = out_reg.truncated;
    assign m_tlast  = out_reg.text_done;

endmodule : utf8_stream_decoder

`default_nettype wire

@@ tb/utf8_stream_decoder_tb.sv @@
// utf8_stream_decoder_tb: self-checking testbench for the utf8 stream decoder
// a directed byte table, then random well-formed and broken text, checked
// against typed rows or an in-bench decoder; depends on utf8d_pkg, utf8_stream_decoder
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

    localparam int RandomItems = 800;
    localparam int QuietTail   = 120;
    localparam int DrainCycles = 4;

    // field widths taken from the package
    localparam int unsigned ByteW    = utf8d_pkg::ByteW;
    localparam int unsigned CpW      = utf8d_pkg::CpW;
    localparam int unsigned CountW   = utf8d_pkg::CountW;
    localparam int unsigned OutDataW = utf8d_pkg::OutDataW;

    // one decoded character as it leaves the block
    typedef struct packed {
        logic [CpW-1:0]    code_point;
        logic [CountW-1:0] byte_count;
        logic              truncated;
        logic              text_done;
    } char_result_t;

    // one row of the directed table
    typedef struct packed {
        logic [ByteW-1:0] text_byte;
        logic             end_of_text;
        logic             typed;
        char_result_t     want;
    } text_row_t;

    localparam char_result_t NoResult = '0;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [ByteW-1:0]    s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // in-bench decoder state
    logic [CountW-1:0] dec_pending = '0;
    logic [CpW-1:0]    dec_value   = '0;
    logic [CountW-1:0] dec_length  = '0;

    char_result_t expected_chars[$];
    text_row_t    text_rows[$];
    int           err_count  = 0;
    int           bytes_sent = 0;
    bit           idle_on    = 1'b1;

    utf8_stream_decoder i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // decode one accepted byte, advancing the in-bench state
    task automatic decode_char(input logic [ByteW-1:0] b, input logic eot,
                               output logic produced, output char_result_t res);
        logic [ByteW-1:0] lead;
        produced = 1'b0;
        res      = NoResult;
        if (dec_pending == '0)
        begin
            if ((b & utf8d_pkg::LeadMask1) == '0)
            begin
                dec_length = utf8d_pkg::Len1;
                lead       = b & utf8d_pkg::Pay1Mask;
            end
            else if ((b & utf8d_pkg::LeadMask2) == utf8d_pkg::LeadCode2)
            begin
                dec_length = utf8d_pkg::Len2;
                lead       = b & utf8d_pkg::Pay2Mask;
            end
            else if ((b & utf8d_pkg::LeadMask3) == utf8d_pkg::LeadCode3)
            begin
                dec_length = utf8d_pkg::Len3;
                lead       = b & utf8d_pkg::Pay3Mask;
            end
            else if ((b & utf8d_pkg::LeadMask4) == utf8d_pkg::LeadCode4)
            begin
                dec_length = utf8d_pkg::Len4;
                lead       = b & utf8d_pkg::Pay4Mask;
            end
            else
            begin
                // stray continuation and 0xf8..0xff leads open a 5-byte run
                dec_length = utf8d_pkg::Len5;
                lead       = b & utf8d_pkg::Pay5Mask;
            end
            dec_value   = CpW'(lead);
            dec_pending = dec_length - 1'b1;
        end
        else
        begin
            // any byte mid-sequence is payload, whatever its prefix
            dec_value   = {dec_value[CpW-7:0], b[5:0]};
            dec_pending = dec_pending - 1'b1;
        end

        if (dec_pending == '0)
        begin
            produced       = 1'b1;
            res.code_point = dec_value;
            res.byte_count = dec_length;
            res.truncated  = 1'b0;
            res.text_done  = eot;
        end
        else if (eot)
        begin
            // text ended early: missing bytes count as zero payload
            produced       = 1'b1;
            res.code_point = dec_value << (6 * dec_pending);
            res.byte_count = dec_length - dec_pending;
            res.truncated  = 1'b1;
            res.text_done  = 1'b1;
        end

        if (produced)
        begin
            dec_pending = '0;
            dec_value   = '0;
            dec_length  = '0;
        end
    endtask

    // drive one request byte and record what it should produce
    task automatic send_byte(input logic [ByteW-1:0] b, input logic eot,
                             input logic typed, input char_result_t want);
        logic         produced;
        char_result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        decode_char(b, eot, produced, predicted);
        if (typed)
            expected_chars.push_back(want);
        else if (produced)
            expected_chars.push_back(predicted);
        bytes_sent++;
    endtask

    // hold off the sender until every expected character has arrived
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
    endtask

    // one random run: mostly well-formed characters, some noise and cut-offs
    task automatic send_random_run();
        int               kind;
        int               n;
        int               cut;
        logic [ByteW-1:0] b;
        logic             eot;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            send_byte(ByteW'($urandom), $urandom_range(0, 15) == 0, 1'b0, NoResult);
        end
        else
        begin
            n   = (kind < 22) ? 5 : $urandom_range(1, 4);
            cut = n;
            if (kind >= 22 && kind < 34)
            begin
                n   = $urandom_range(2, 5);
                cut = $urandom_range(1, n - 1);
            end
            for (int i = 1; i <= cut; i++)
            begin
                if (i == 1)
                begin
                    case (n)
                        1:       b = {1'b0, 7'($urandom)};
                        2:       b = {3'b110, 5'($urandom)};
                        3:       b = {4'b1110, 4'($urandom)};
                        4:       b = {5'b11110, 3'($urandom)};
                        default: b = $urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                                          : {5'b11111, 3'($urandom)};
                    endcase
                end
                else if ($urandom_range(0, 15) == 0)
                    b = ByteW'($urandom);
                else
                    b = {2'b10, 6'($urandom)};
                if (i == cut)
                    eot = (cut < n) ? 1'b1 : ($urandom_range(0, 9) == 0);
                else
                    eot = 1'b0;
                send_byte(b, eot, 1'b0, NoResult);
            end
        end
    endtask

    // receiver: random stall bursts while idling is on
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected result: code_point %h", m_tdata[CpW-1:0]);
                err_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata[CpW-1:0] !== want.code_point)
                begin
                    $error("code_point: expected %h, actual %h",
                           want.code_point, m_tdata[CpW-1:0]);
                    err_count++;
                end
                if (m_tdata[CpW+CountW-1:CpW] !== want.byte_count)
                begin
                    $error("byte_count: expected %0d, actual %0d",
                           want.byte_count, m_tdata[CpW+CountW-1:CpW]);
                    err_count++;
                end
                if (m_tuser !== want.truncated)
                begin
                    $error("truncated: expected %b, actual %b", want.truncated, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.text_done)
                begin
                    $error("text_done: expected %b, actual %b", want.text_done, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int total;
        bit mid_pause;
        total     = 0;
        mid_pause = 1'b0;

        // directed table: typed rows carry their result, the rest are predicted
        text_rows.push_back('{8'h00, 1'b0, 1'b1,
                              '{26'h0000000, utf8d_pkg::Len1, 1'b0, 1'b0}});
        text_rows.push_back('{8'h7F, 1'b0, 1'b1,
                              '{26'h000007F, utf8d_pkg::Len1, 1'b0, 1'b0}});
        text_rows.push_back('{8'hC2, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'hA9, 1'b0, 1'b0, NoResult});
        // widest 5-byte form, all payload bits set
        text_rows.push_back('{8'hFF, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'hFF, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'hFF, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'hFF, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'hFF, 1'b0, 1'b1,
                              '{26'h3FFFFFF, utf8d_pkg::Len5, 1'b0, 1'b0}});
        // stray continuation as lead, followers with foreign prefixes
        text_rows.push_back('{8'h80, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'h41, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'hC0, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'h00, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'h7F, 1'b0, 1'b0, NoResult});
        // end of text right after a lead byte
        text_rows.push_back('{8'hC3, 1'b1, 1'b1,
                              '{26'h00000C0, utf8d_pkg::Len1, 1'b1, 1'b1}});
        // end of text on a single-byte character
        text_rows.push_back('{8'h41, 1'b1, 1'b1,
                              '{26'h0000041, utf8d_pkg::Len1, 1'b0, 1'b1}});
        // end of text one byte short
        text_rows.push_back('{8'hE2, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'h82, 1'b1, 1'b0, NoResult});
        // end of text on the completing byte
        text_rows.push_back('{8'hF0, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'h9F, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'h98, 1'b0, 1'b0, NoResult});
        text_rows.push_back('{8'h80, 1'b1, 1'b0, NoResult});

        // reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (text_rows[i])
            send_byte(text_rows[i].text_byte, text_rows[i].end_of_text,
                      text_rows[i].typed, text_rows[i].want);
        wait_for_drain();

        // random part: idling in alternating stretches, none at the tail
        total = bytes_sent + RandomItems;
        while (bytes_sent < total)
        begin
            idle_on = ((bytes_sent / 100) % 2 == 0) && (bytes_sent < total - QuietTail);
            if (!mid_pause && bytes_sent >= total - RandomItems / 2)
            begin
                mid_pause = 1'b1;
                wait_for_drain();
            end
            send_random_run();
        end

        // drain and settle
        wait_for_drain();
        repeat (DrainCycles) @(posedge clk);

        if (err_count == 0 && expected_chars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ utf8_stream_decoder.f @@
sv/utf8d_pkg.sv
sv/utf8d_core.sv
sv/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
